// ----- sv/frsc_pkg.sv -----
`default_nettype none

package frsc_pkg;

    localparam int RAW_W   = 13;
    localparam int VOLT_W  = 12;
    localparam int SUP_W   = 13;
    localparam int RES_W   = 20;
    localparam int WORD_W  = 32;
    localparam int BITS_W  = 4;
    localparam int ATT_W   = 2;

    // shared divider: dividend covers R * (supply - v), divisor covers resistance
    localparam int NUM_W   = 33;
    localparam int DEN_W   = 32;
    localparam int MULA_W  = 20;
    localparam int MULB_W  = 13;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_BITS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTEN_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_MV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_OHM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_GAIN = 3'd4;

    localparam logic [BITS_W-1:0] ADC_BITS_RST   = 4'd12;
    localparam logic [ATT_W-1:0]  ATTEN_RST      = 2'd3;
    localparam logic [SUP_W-1:0]  SUPPLY_RST     = 13'd3300;
    localparam logic [RES_W-1:0]  FIXED_OHM_RST  = 20'd10000;
    localparam logic [WORD_W-1:0] FORCE_GAIN_RST = 32'd327680000;

    localparam logic [WORD_W-1:0] OPEN_CIRCUIT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] PRESS_LIMIT  = 32'd1000000;

    typedef struct packed {
        logic [RAW_W-1:0] raw_sample;
        logic             sample_ok;
        logic             last_sample;
    } sample_t;

    typedef struct packed {
        logic [RAW_W-1:0]  avg_raw;
        logic [VOLT_W-1:0] sense_mv;
        logic [WORD_W-1:0] resistance_ohm;
        logic [WORD_W-1:0] force_q16;
        logic              pressed;
        logic              sense_ok;
        logic              read_failed;
    } result_t;

    function automatic logic [VOLT_W-1:0] full_scale(input logic [ATT_W-1:0] mode);
        logic [VOLT_W-1:0] fs;
        unique case (mode)
            2'd0:    fs = 12'd1100;
            2'd1:    fs = 12'd1474;
            2'd2:    fs = 12'd2200;
            default: fs = 12'd3100;
        endcase
        return fs;
    endfunction

    // clamp resolution to 9..13 bits, full-scale code is 2^bits - 1
    function automatic logic [RAW_W-1:0] max_code(input logic [BITS_W-1:0] bits);
        logic [RAW_W-1:0] mc;
        priority if (bits <= 4'd9)
            mc = 13'h01FF;
        else if (bits >= 4'd13)
            mc = 13'h1FFF;
        else if (bits == 4'd10)
            mc = 13'h03FF;
        else if (bits == 4'd11)
            mc = 13'h07FF;
        else
            mc = 13'h0FFF;
        return mc;
    endfunction

endpackage

`default_nettype wire

// ----- sv/frsc_acc.sv -----
`default_nettype none

module frsc_acc
    import frsc_pkg::*;
#(
    parameter int MAX_SAMPLES = 256,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
    parameter int SUM_W       = RAW_W + CNT_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire sample_t          word,
    output logic      [SUM_W-1:0] sum_next,
    output logic      [CNT_W-1:0] cnt_next
);

    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             take;

    // drop good samples once the burst is full
    assign take     = word.sample_ok && (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign sum_next = take ? sum_reg + SUM_W'(word.raw_sample) : sum_reg;
    assign cnt_next = take ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (word.last_sample)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/frsc_div.sv -----
`default_nettype none

module frsc_div
    import frsc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            den_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sv/force_resistor_sample_converter.sv -----
`default_nettype none

// Channel  | Valid         | Flow        | Payload
// ---------+---------------+-------------+-----------------------------
// sample   | sample_valid  | sample_stall| sample    (sample_t)
// result   | result_valid  | result_stall| result    (result_t)
// cfg      | cfg_valid     | cfg_ready   | cfg_index, cfg_data
//
// A sample that is not last feeds only the burst sum and count. A last
// sample runs up to four divisions through one shared restoring divider,
// then loads its result once the output register is free.
// sample_stall is high from a last sample until its result is loaded into
// the output register. Reset clears the burst sum and count and loads the
// register defaults; there is no clearing pass.

module force_resistor_sample_converter
    import frsc_pkg::*;
#(
    parameter int MAX_SAMPLES = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire sample_t              sample,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = RAW_W + CNT_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIV_AVG = 4'd1;
    localparam logic [3:0] S_MUL_V   = 4'd2;
    localparam logic [3:0] S_DIV_V   = 4'd3;
    localparam logic [3:0] S_RES     = 4'd4;
    localparam logic [3:0] S_DIV_R   = 4'd5;
    localparam logic [3:0] S_FORCE   = 4'd6;
    localparam logic [3:0] S_DIV_F   = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [BITS_W-1:0] adc_bits_reg;
    logic [ATT_W-1:0]  atten_reg;
    logic [SUP_W-1:0]  supply_reg;
    logic [RES_W-1:0]  fixed_ohm_reg;
    logic [WORD_W-1:0] gain_reg;

    logic [3:0]        state_reg, state_next;
    logic              accept;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_next;

    logic              div_start_reg, div_start_next;
    logic [NUM_W-1:0]  div_num_reg, div_num_next;
    logic [DEN_W-1:0]  div_den_reg, div_den_next;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;

    logic [RAW_W-1:0]  avg_reg, avg_next;
    logic [VOLT_W-1:0] volt_reg, volt_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] force_reg, force_next;
    logic              fail_reg, fail_next;

    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic              load_out;

    logic [VOLT_W-1:0] fs;
    logic [MULA_W-1:0] mul_a;
    logic [MULB_W-1:0] mul_b;
    logic [NUM_W-1:0]  product;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign fs           = full_scale(atten_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_bits_reg  <= ADC_BITS_RST;
            atten_reg     <= ATTEN_RST;
            supply_reg    <= SUPPLY_RST;
            fixed_ohm_reg <= FIXED_OHM_RST;
            gain_reg      <= FORCE_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ADC_BITS:   adc_bits_reg  <= cfg_data[BITS_W-1:0];
                REG_ATTEN_MODE: atten_reg     <= cfg_data[ATT_W-1:0];
                REG_SUPPLY_MV:  supply_reg    <= cfg_data[SUP_W-1:0];
                REG_FIXED_OHM:  fixed_ohm_reg <= cfg_data[RES_W-1:0];
                REG_FORCE_GAIN: gain_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    frsc_acc #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .word     (sample),
        .sum_next (sum_next),
        .cnt_next (cnt_next)
    );

    frsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // shared multiplier: avg * full scale, then R * (supply - v)
    assign mul_a   = (state_reg == S_MUL_V) ? MULA_W'(avg_reg) : fixed_ohm_reg;
    assign mul_b   = (state_reg == S_MUL_V) ? MULB_W'(fs)
                                            : supply_reg - SUP_W'(volt_reg);
    assign product = NUM_W'(mul_a) * NUM_W'(mul_b);

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        state_next     = state_reg;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        avg_next       = avg_reg;
        volt_next      = volt_reg;
        res_next       = res_reg;
        force_next     = force_reg;
        fail_next      = fail_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && sample.last_sample)
                begin
                    avg_next   = '0;
                    volt_next  = '0;
                    res_next   = '0;
                    force_next = '0;
                    if (cnt_next == '0)
                    begin
                        fail_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        fail_next      = 1'b0;
                        div_num_next   = NUM_W'(sum_next);
                        div_den_next   = DEN_W'(cnt_next);
                        div_start_next = 1'b1;
                        state_next     = S_DIV_AVG;
                    end
                end
            end
            S_DIV_AVG:
            begin
                if (div_done)
                begin
                    avg_next   = div_quo[RAW_W-1:0];
                    state_next = S_MUL_V;
                end
            end
            S_MUL_V:
            begin
                div_num_next   = product;
                div_den_next   = DEN_W'(max_code(adc_bits_reg));
                div_start_next = 1'b1;
                state_next     = S_DIV_V;
            end
            S_DIV_V:
            begin
                if (div_done)
                begin
                    // clamp voltages above full scale
                    volt_next  = (div_quo > NUM_W'(fs)) ? fs : div_quo[VOLT_W-1:0];
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                priority if (volt_reg == '0)
                begin
                    res_next   = OPEN_CIRCUIT;
                    state_next = S_FORCE;
                end
                else if (SUP_W'(volt_reg) >= supply_reg)
                begin
                    res_next   = '0;
                    state_next = S_FORCE;
                end
                else
                begin
                    div_num_next   = product;
                    div_den_next   = DEN_W'(volt_reg);
                    div_start_next = 1'b1;
                    state_next     = S_DIV_R;
                end
            end
            S_DIV_R:
            begin
                if (div_done)
                begin
                    res_next   = div_quo[NUM_W-1] ? OPEN_CIRCUIT : div_quo[WORD_W-1:0];
                    state_next = S_FORCE;
                end
            end
            S_FORCE:
            begin
                if (res_reg == '0 || res_reg >= PRESS_LIMIT)
                begin
                    force_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    div_num_next   = NUM_W'(gain_reg);
                    div_den_next   = res_reg;
                    div_start_next = 1'b1;
                    state_next     = S_DIV_F;
                end
            end
            S_DIV_F:
            begin
                if (div_done)
                begin
                    force_next = div_quo[WORD_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        avg_reg     <= avg_next;
        volt_reg    <= volt_next;
        res_reg     <= res_next;
        force_reg   <= force_next;
        fail_reg    <= fail_next;
        if (load_out)
        begin
            out_reg.avg_raw        <= avg_reg;
            out_reg.sense_mv       <= volt_reg;
            out_reg.resistance_ohm <= res_reg;
            out_reg.force_q16      <= force_reg;
            out_reg.pressed        <= !fail_reg && (res_reg < PRESS_LIMIT);
            out_reg.sense_ok       <= (avg_reg != '0);
            out_reg.read_failed    <= fail_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import frsc_pkg::*;

    localparam int MAX_GOOD     = 256;
    localparam int PHASE_ITEMS  = 95;
    localparam int LONG_BURST   = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int MAX_REPORTS  = 40;

    localparam logic [ATT_W-1:0] ATT_1100 = 2'd0;
    localparam logic [ATT_W-1:0] ATT_1474 = 2'd1;
    localparam logic [ATT_W-1:0] ATT_2200 = 2'd2;
    localparam logic [ATT_W-1:0] ATT_3100 = 2'd3;

    class reading_scoreboard;
        logic [BITS_W-1:0] adc_bits;
        logic [ATT_W-1:0]  atten_mode;
        logic [SUP_W-1:0]  supply_mv;
        logic [RES_W-1:0]  fixed_ohm;
        logic [WORD_W-1:0] force_gain;
        logic [20:0]       sample_sum;
        logic [8:0]        good_count;
        result_t           pending_readings[$];
        int                errors;

        function new();
            adc_bits   = ADC_BITS_RST;
            atten_mode = ATTEN_RST;
            supply_mv  = SUPPLY_RST;
            fixed_ohm  = FIXED_OHM_RST;
            force_gain = FORCE_GAIN_RST;
            sample_sum = '0;
            good_count = '0;
            errors     = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                REG_ADC_BITS:   adc_bits   = data[BITS_W-1:0];
                REG_ATTEN_MODE: atten_mode = data[ATT_W-1:0];
                REG_SUPPLY_MV:  supply_mv  = data[SUP_W-1:0];
                REG_FIXED_OHM:  fixed_ohm  = data[RES_W-1:0];
                REG_FORCE_GAIN: force_gain = data;
                default: ;
            endcase
        endfunction

        function logic [VOLT_W-1:0] full_scale_mv(logic [ATT_W-1:0] mode);
            case (mode)
                ATT_1100: return 12'd1100;
                ATT_1474: return 12'd1474;
                ATT_2200: return 12'd2200;
                default:  return 12'd3100;
            endcase
        endfunction

        function result_t predict_reading();
            result_t           r;
            logic [BITS_W-1:0] bits;
            logic [RAW_W-1:0]  code_max;
            logic [VOLT_W-1:0] fs;
            logic [63:0]       volts;
            logic [63:0]       ohms;
            r = '0;
            if (good_count == 0) begin
                r.read_failed = 1'b1;
                return r;
            end
            r.avg_raw = RAW_W'(sample_sum / good_count);
            bits = (adc_bits < 4'd9) ? 4'd9 : ((adc_bits > 4'd13) ? 4'd13 : adc_bits);
            code_max = RAW_W'((32'd1 << bits) - 32'd1);
            fs = full_scale_mv(atten_mode);
            volts = 64'(r.avg_raw) * 64'(fs) / 64'(code_max);
            if (volts > 64'(fs))
                volts = 64'(fs);
            r.sense_mv = VOLT_W'(volts);
            // divider inversion: open circuit at zero volts, short at or above supply
            if (r.sense_mv == 0)
                r.resistance_ohm = OPEN_CIRCUIT;
            else if (SUP_W'(r.sense_mv) >= supply_mv)
                r.resistance_ohm = '0;
            else
            begin
                ohms = 64'(fixed_ohm) * 64'(supply_mv - SUP_W'(r.sense_mv))
                       / 64'(r.sense_mv);
                r.resistance_ohm = (ohms > 64'(OPEN_CIRCUIT)) ? OPEN_CIRCUIT : 32'(ohms);
            end
            r.pressed = r.resistance_ohm < PRESS_LIMIT;
            if (r.resistance_ohm != 0 && r.pressed)
                r.force_q16 = force_gain / r.resistance_ohm;
            r.sense_ok = r.avg_raw != 0;
            return r;
        endfunction

        function void note_sample(sample_t s);
            // drop good samples past the burst limit
            if (s.sample_ok && good_count < MAX_GOOD)
            begin
                sample_sum = sample_sum + 21'(s.raw_sample);
                good_count = good_count + 9'd1;
            end
            if (s.last_sample)
            begin
                pending_readings.push_back(predict_reading());
                sample_sum = '0;
                good_count = '0;
            end
        endfunction

        function void compare(string field, logic [WORD_W-1:0] want_v,
                              logic [WORD_W-1:0] got_v);
            if (want_v !== got_v)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %0h actual %0h", $time, field, want_v, got_v);
            end
        endfunction

        function void check_reading(result_t got);
            result_t want;
            if (pending_readings.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: reading with none expected, expected nothing actual %h",
                             $time, got);
                return;
            end
            want = pending_readings.pop_front();
            compare("avg_raw", 32'(want.avg_raw), 32'(got.avg_raw));
            compare("sense_mv", 32'(want.sense_mv), 32'(got.sense_mv));
            compare("resistance_ohm", want.resistance_ohm, got.resistance_ohm);
            compare("force_q16", want.force_q16, got.force_q16);
            compare("pressed", 32'(want.pressed), 32'(got.pressed));
            compare("sense_ok", 32'(want.sense_ok), 32'(got.sense_ok));
            compare("read_failed", 32'(want.read_failed), 32'(got.read_failed));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;

    reading_scoreboard board;
    int sender_gap_pct = 20;
    int recv_stall_pct = 72;
    int cycle_count = 0;

    force_resistor_sample_converter #(.MAX_SAMPLES(MAX_GOOD)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // take result words and pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_reading(result);
        result_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_sample(input logic [RAW_W-1:0] raw, input logic ok,
                               input logic last);
        sample_t s;
        s.raw_sample  = raw;
        s.sample_ok   = ok;
        s.last_sample = last;
        while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        board.note_sample(s);
    endtask

    function automatic logic [RAW_W-1:0] random_raw();
        case ($urandom_range(3))
            0:       return RAW_W'($urandom_range((1 << RAW_W) - 1));
            1:       return RAW_W'($urandom_range(511));
            2:       return RAW_W'($urandom_range(4095));
            default: return RAW_W'($urandom_range(31));
        endcase
    endfunction

    task automatic run_random_bursts(input int item_budget);
        int sent;
        int len;
        int ok_pct;
        sent = 0;
        while (sent < item_budget)
        begin
            len = $urandom_range(1, 8);
            // now and then a burst with every read failing
            ok_pct = ($urandom_range(9) == 0) ? 0 : 85;
            for (int i = 0; i < len; i++)
                send_sample(random_raw(), $urandom_range(99) < ok_pct, i == len - 1);
            sent += len;
        end
    endtask

    // hold off until every reading is out and the divider has gone quiet
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (board.pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.apply_reg(idx, data);
    endtask

    task automatic load_setting(input logic [BITS_W-1:0] bits, input logic [ATT_W-1:0] mode,
                                input logic [SUP_W-1:0] supply, input logic [RES_W-1:0] ohm,
                                input logic [WORD_W-1:0] gain);
        wait_idle();
        // junk in the upper bits must be dropped
        write_reg(REG_ADC_BITS, {28'($urandom()), bits});
        write_reg(REG_ATTEN_MODE, {30'($urandom()), mode});
        write_reg(REG_SUPPLY_MV, {19'($urandom()), supply});
        write_reg(REG_FIXED_OHM, {12'($urandom()), ohm});
        write_reg(REG_FORCE_GAIN, gain);
        write_reg(CFG_IDX_W'($urandom_range(REG_FORCE_GAIN + 1, (1 << CFG_IDX_W) - 1)),
                  $urandom());
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(13'h1FFF, 1'b0, 1'b1);
        send_sample(13'h0000, 1'b1, 1'b1);
        send_sample(13'h1FFF, 1'b1, 1'b1);
        send_sample(13'd4095, 1'b1, 1'b0);
        send_sample(13'd1234, 1'b0, 1'b1);
        send_sample(13'd1, 1'b1, 1'b0);
        send_sample(13'd2, 1'b1, 1'b0);
        send_sample(13'd5000, 1'b0, 1'b0);
        send_sample(13'd3, 1'b1, 1'b1);
        send_sample(13'd2000, 1'b1, 1'b1);
        send_sample(13'd4000, 1'b1, 1'b1);
        send_sample(13'h1555, 1'b1, 1'b1);
        send_sample(13'h0AAA, 1'b1, 1'b1);
        send_sample(13'd100, 1'b0, 1'b0);
        send_sample(13'd200, 1'b0, 1'b0);
        send_sample(13'd300, 1'b0, 1'b1);
        run_random_bursts(PHASE_ITEMS);

        load_setting(4'd0, ATT_1100, 13'd0, 20'd1, 32'hFFFF_FFFF);
        run_random_bursts(PHASE_ITEMS);
        load_setting(4'd15, ATT_1474, 13'h1FFF, 20'hF_FFFF, 32'hFFFF_FFFF);
        run_random_bursts(PHASE_ITEMS);

        sender_gap_pct = 72;
        recv_stall_pct = 20;
        load_setting(4'd13, ATT_2200, 13'd5000, 20'd1000000, 32'd327680000);
        for (int i = 0; i < LONG_BURST; i++)
            send_sample(random_raw(), 1'b1, i == LONG_BURST - 1);
        run_random_bursts(PHASE_ITEMS);
        load_setting(4'd10, ATT_3100, 13'd1, 20'd500, 32'd0);
        run_random_bursts(PHASE_ITEMS);
        load_setting(4'd11, ATT_1100, 13'd1500, 20'd47000, $urandom());
        run_random_bursts(PHASE_ITEMS);

        sender_gap_pct = 0;
        recv_stall_pct = 0;
        load_setting(4'd9, ATT_2200, 13'd3300, 20'd10000, 32'h8000_0000);
        run_random_bursts(PHASE_ITEMS);
        load_setting(BITS_W'($urandom_range(15)), ATT_W'($urandom_range(3)),
                     SUP_W'($urandom_range((1 << SUP_W) - 1)),
                     RES_W'($urandom_range(1, (1 << RES_W) - 1)), $urandom());
        run_random_bursts(PHASE_ITEMS);
        load_setting(ADC_BITS_RST, ATTEN_RST, SUPPLY_RST, FIXED_OHM_RST, FORCE_GAIN_RST);
        run_random_bursts(PHASE_ITEMS);

        wait_idle();
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
